[design/tofwc_pkg.sv]
`default_nettype none
package tofwc_pkg;

   localparam int PE_W       = 17;
   localparam int TOF_W      = 26;
   localparam int COEF_W     = 24;
   localparam int OFS_W      = 21;
   localparam int STEP_W     = 13;
   localparam int MASK_W     = 8;
   localparam int Q_W        = 17;
   localparam int NUM_W      = 49;
   localparam int ROOT_W     = 25;
   localparam int PROD_W     = COEF_W + Q_W + 1;
   localparam int LIN_W      = 25;
   localparam int SUM_W      = 30;
   localparam int DIV_STEPS  = NUM_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int ROOT_LAT   = DIV_STEPS + SQRT_STEPS;

   localparam logic [24:0] PE_GAIN_A = 25'd5610;
   localparam logic [24:0] PE_OFFS_A = 25'd137098;
   localparam logic [24:0] PE_GAIN_B = 25'd5741;
   localparam logic [24:0] PE_OFFS_B = 25'd147584;
   localparam logic signed [Q_W:0] PED_A = 18'sd896;
   localparam logic signed [Q_W:0] PED_B = 18'sd947;
   localparam logic signed [TOF_W-1:0] TOF_SHIFT = 26'sd550;
   localparam logic [STEP_W-1:0] STEP_RESET = 13'd640;

   typedef enum logic [2:0] {
      REG_OFS1  = 3'd0,
      REG_ROOT1 = 3'd1,
      REG_LIN1  = 3'd2,
      REG_OFS2  = 3'd3,
      REG_ROOT2 = 3'd4,
      REG_LIN2  = 3'd5,
      REG_STEP  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [OFS_W-1:0]  ofs1;
      logic signed [COEF_W-1:0] root1;
      logic signed [COEF_W-1:0] lin1;
      logic signed [OFS_W-1:0]  ofs2;
      logic signed [COEF_W-1:0] root2;
      logic signed [COEF_W-1:0] lin2;
      logic [STEP_W-1:0]        step;
   } cfg_type;

   typedef struct packed {
      logic                     eok;
      logic                     wok;
      logic signed [TOF_W-1:0]  tof_raw;
      logic [PE_W-1:0]          pa;
      logic [PE_W-1:0]          pb;
      logic [MASK_W-1:0]        mask;
      logic signed [PROD_W-1:0] prod_a;
      logic signed [PROD_W-1:0] prod_b;
   } front_type;

   typedef struct packed {
      logic                    eok;
      logic                    wok;
      logic signed [TOF_W-1:0] tof_raw;
      logic [PE_W-1:0]         pa;
      logic [PE_W-1:0]         pb;
      logic [MASK_W-1:0]       mask;
      logic signed [LIN_W-1:0] lin_a;
      logic signed [LIN_W-1:0] lin_b;
   } side_type;

endpackage
`default_nettype wire

[design/tofwc_front.sv]
`default_nettype none
module tofwc_front #(
   parameter int NUM_CLASSES = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire logic [23:0]                   time_a,
   input  wire logic [23:0]                   time_b,
   input  wire logic [11:0]                   height_a,
   input  wire logic [11:0]                   height_b,
   input  wire tofwc_pkg::cfg_type            cfg,
   output logic                               out_valid,
   output tofwc_pkg::front_type               out_data,
   output logic [tofwc_pkg::NUM_W-1:0]        num_a,
   output logic [tofwc_pkg::Q_W-1:0]          div_a,
   output logic [tofwc_pkg::NUM_W-1:0]        num_b,
   output logic [tofwc_pkg::Q_W-1:0]          div_b
);
   import tofwc_pkg::*;

   localparam int NC = (NUM_CLASSES < MASK_W) ? NUM_CLASSES : MASK_W;

   logic                    s1_v_ff;
   logic                    s1_eok_ff, s1_eok_in;
   logic [PE_W-1:0]         s1_pa_ff, s1_pa_in, s1_pb_ff, s1_pb_in;
   logic signed [TOF_W-1:0] s1_tof_ff, s1_tof_in;

   logic                    s2_v_ff;
   front_type               s2_ff, s2_in;
   logic [NUM_W-1:0]        s2_num_a_ff, s2_num_a_in, s2_num_b_ff, s2_num_b_in;
   logic [Q_W-1:0]          s2_div_a_ff, s2_div_a_in, s2_div_b_ff, s2_div_b_in;

   logic signed [Q_W:0]     qa, qb;
   logic [COEF_W-1:0]       mag_a, mag_b;
   logic [2*COEF_W-1:0]     sq_a, sq_b;
   logic [PE_W-1:0]         thr;

   always_comb begin
      s1_eok_in = (|time_a) & (|time_b) & (|height_a) & (|height_b);
      s1_pa_in  = PE_W'((25'(height_a) * PE_GAIN_A + PE_OFFS_A) >> 8);
      s1_pb_in  = PE_W'((25'(height_b) * PE_GAIN_B + PE_OFFS_B) >> 8);
      s1_tof_in = $signed({2'b00, time_a}) - $signed({2'b00, time_b}) - TOF_SHIFT;
   end

   always_comb begin
      qa = $signed({1'b0, s1_pa_ff}) - PED_A;
      qb = $signed({1'b0, s1_pb_ff}) - PED_B;
      mag_a = cfg.root1[COEF_W-1] ? COEF_W'(-cfg.root1) : COEF_W'(cfg.root1);
      mag_b = cfg.root2[COEF_W-1] ? COEF_W'(-cfg.root2) : COEF_W'(cfg.root2);
      sq_a = mag_a * mag_a;
      sq_b = mag_b * mag_b;
      s2_num_a_in = {sq_a[NUM_W-3:0], 2'b00};
      s2_num_b_in = {sq_b[NUM_W-3:0], 2'b00};
      s2_div_a_in = (qa > 0) ? qa[Q_W-1:0] : Q_W'(1);
      s2_div_b_in = (qb > 0) ? qb[Q_W-1:0] : Q_W'(1);
      s2_in.eok = s1_eok_ff;
      s2_in.wok = s1_eok_ff & (qa > 0) & (qb > 0);
      s2_in.tof_raw = s1_tof_ff;
      s2_in.pa = s1_pa_ff;
      s2_in.pb = s1_pb_ff;
      s2_in.prod_a = PROD_W'(cfg.lin1 * qa);
      s2_in.prod_b = PROD_W'(cfg.lin2 * qb);
      s2_in.mask = '0;
      thr = '0;
      for (int k = 0; k < NC; k++) begin
         thr = PE_W'(PE_W'(cfg.step) * PE_W'(k + 1));
         s2_in.mask[k] = (s1_pa_ff > thr) & (s1_pb_ff > thr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_eok_ff   <= s1_eok_in;
         s1_pa_ff    <= s1_pa_in;
         s1_pb_ff    <= s1_pb_in;
         s1_tof_ff   <= s1_tof_in;
         s2_ff       <= s2_in;
         s2_num_a_ff <= s2_num_a_in;
         s2_num_b_ff <= s2_num_b_in;
         s2_div_a_ff <= s2_div_a_in;
         s2_div_b_ff <= s2_div_b_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_data  = s2_ff;
   assign num_a     = s2_num_a_ff;
   assign num_b     = s2_num_b_ff;
   assign div_a     = s2_div_a_ff;
   assign div_b     = s2_div_b_ff;

endmodule
`default_nettype wire

[design/tofwc_root.sv]
`default_nettype none
module tofwc_root (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire logic [tofwc_pkg::NUM_W-1:0]   num,
   input  wire logic [tofwc_pkg::Q_W-1:0]     div,
   output logic [tofwc_pkg::ROOT_W-1:0]       root
);
   import tofwc_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   // restoring divide, one quotient bit per stage; quotient shifts into nq
   logic [Q_W-1:0]   d_rem_ff [DIV_STEPS];
   logic [NUM_W-1:0] d_nq_ff  [DIV_STEPS];
   logic [Q_W-1:0]   d_div_ff [DIV_STEPS];

   // digit-by-digit square root, two radicand bits per stage
   logic [RAD_W-1:0]  s_rad_ff  [SQRT_STEPS];
   logic [REM_W-1:0]  s_rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0] s_root_ff [SQRT_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      logic [Q_W-1:0]   rem_prev, div_prev;
      logic [NUM_W-1:0] nq_prev;
      logic [Q_W:0]     r_try;
      logic             ge;
      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign div_prev = div;
      end else begin : g_next
         assign rem_prev = d_rem_ff[i-1];
         assign nq_prev  = d_nq_ff[i-1];
         assign div_prev = d_div_ff[i-1];
      end
      assign r_try = {rem_prev, nq_prev[NUM_W-1]};
      assign ge    = r_try >= {1'b0, div_prev};
      always_ff @(posedge clock) begin
         if (adv) begin
            d_rem_ff[i] <= ge ? Q_W'(r_try - {1'b0, div_prev}) : Q_W'(r_try);
            d_nq_ff[i]  <= {nq_prev[NUM_W-2:0], ge};
            d_div_ff[i] <= div_prev;
         end
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REM_W+1:0]  cur, trial;
      logic              ge;
      if (j == 0) begin : g_first
         assign rad_prev  = RAD_W'(d_nq_ff[DIV_STEPS-1]);
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = s_rad_ff[j-1];
         assign rem_prev  = s_rem_ff[j-1];
         assign root_prev = s_root_ff[j-1];
      end
      assign cur   = {rem_prev, rad_prev[RAD_W-1:RAD_W-2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign ge    = cur >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            s_rad_ff[j]  <= {rad_prev[RAD_W-3:0], 2'b00};
            s_rem_ff[j]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
            s_root_ff[j] <= {root_prev[ROOT_W-2:0], ge};
         end
      end
   end

   assign root = s_root_ff[SQRT_STEPS-1];

endmodule
`default_nettype wire

[design/tof_walk_correction.sv]
`default_nettype none
// channel  | ports                                        | handshake
// req      | time_a, time_b, height_a, height_b           | req_valid / req_ready
// rsp      | event_ok, walk_ok, tof_ps, pe_a, pe_b, class_mask | rsp_valid / rsp_ready
// csr      | csr_index, csr_wdata                         | csr_we, no wait
// One transaction per cycle unless the output stalls; two front stages, a 49-stage
// restoring divider and a 25-stage square root per channel, one output stage.
// The whole pipe advances when the output register is empty or taken, so a
// stalled result holds every stage in place. Reset clears valid bits and
// loads the register defaults.
module tof_walk_correction #(
   parameter int NUM_CLASSES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [23:0] req_time_a,
   input  wire logic [23:0] req_time_b,
   input  wire logic [11:0] req_height_a,
   input  wire logic [11:0] req_height_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_event_ok,
   output logic             rsp_walk_ok,
   output logic signed [25:0] rsp_tof_ps,
   output logic [16:0]      rsp_pe_a,
   output logic [16:0]      rsp_pe_b,
   output logic [7:0]       rsp_class_mask,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   import tofwc_pkg::*;

   logic             adv;
   cfg_type          cfg_ff;
   logic             front_v;
   front_type        front_d;
   logic [NUM_W-1:0] num_a, num_b;
   logic [Q_W-1:0]   div_a, div_b;
   logic [ROOT_W-1:0] root_a, root_b;

   logic     side_v_ff [ROOT_LAT];
   side_type side_ff   [ROOT_LAT];
   side_type side_in;

   logic                    rsp_valid_ff;
   logic                    rsp_eok_ff, rsp_eok_in, rsp_wok_ff, rsp_wok_in;
   logic signed [TOF_W-1:0] rsp_tof_ff, rsp_tof_in;
   logic [PE_W-1:0]         rsp_pa_ff, rsp_pa_in, rsp_pb_ff, rsp_pb_in;
   logic [MASK_W-1:0]       rsp_mask_ff, rsp_mask_in;

   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{step: STEP_RESET, default: '0};
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_OFS1:  cfg_ff.ofs1  <= csr_wdata[OFS_W-1:0];
            REG_ROOT1: cfg_ff.root1 <= csr_wdata;
            REG_LIN1:  cfg_ff.lin1  <= csr_wdata;
            REG_OFS2:  cfg_ff.ofs2  <= csr_wdata[OFS_W-1:0];
            REG_ROOT2: cfg_ff.root2 <= csr_wdata;
            REG_LIN2:  cfg_ff.lin2  <= csr_wdata;
            REG_STEP:  cfg_ff.step  <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   tofwc_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
      .clock, .reset, .adv,
      .in_valid (req_valid),
      .time_a   (req_time_a),
      .time_b   (req_time_b),
      .height_a (req_height_a),
      .height_b (req_height_b),
      .cfg      (cfg_ff),
      .out_valid(front_v),
      .out_data (front_d),
      .num_a, .div_a, .num_b, .div_b
   );

   tofwc_root u_root_a (.clock, .adv, .num(num_a), .div(div_a), .root(root_a));
   tofwc_root u_root_b (.clock, .adv, .num(num_b), .div(div_b), .root(root_b));

   function automatic logic signed [LIN_W-1:0] lin_round(logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] t;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      t   = (mag + PROD_W'(1 << 17)) >> 18;
      return p[PROD_W-1] ? LIN_W'(-$signed(t)) : LIN_W'($signed(t));
   endfunction

   always_comb begin
      side_in.eok     = front_d.eok;
      side_in.wok     = front_d.wok;
      side_in.tof_raw = front_d.tof_raw;
      side_in.pa      = front_d.pa;
      side_in.pb      = front_d.pb;
      side_in.mask    = front_d.mask;
      side_in.lin_a   = lin_round(front_d.prod_a);
      side_in.lin_b   = lin_round(front_d.prod_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_LAT; i++) side_v_ff[i] <= 1'b0;
      end else if (adv) begin
         side_v_ff[0] <= front_v;
         for (int i = 1; i < ROOT_LAT; i++) side_v_ff[i] <= side_v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < ROOT_LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   side_type                last;
   logic [ROOT_W-1:0]       t_a, t_b;
   logic signed [SUM_W-1:0] walk_a, walk_b, tof_sum;

   always_comb begin
      last = side_ff[ROOT_LAT-1];
      t_a  = ROOT_W'(({1'b0, root_a} + (ROOT_W+1)'(1)) >> 1);
      t_b  = ROOT_W'(({1'b0, root_b} + (ROOT_W+1)'(1)) >> 1);
      walk_a = SUM_W'(cfg_ff.ofs1) + SUM_W'(last.lin_a) +
               (cfg_ff.root1[COEF_W-1] ? -$signed(SUM_W'(t_a)) : $signed(SUM_W'(t_a)));
      walk_b = SUM_W'(cfg_ff.ofs2) + SUM_W'(last.lin_b) +
               (cfg_ff.root2[COEF_W-1] ? -$signed(SUM_W'(t_b)) : $signed(SUM_W'(t_b)));
      tof_sum = SUM_W'(last.tof_raw);
      if (last.wok) tof_sum = tof_sum - walk_a - walk_b;
      if (tof_sum > SUM_W'(33554431))       rsp_tof_in = 26'sh1FFFFFF;
      else if (tof_sum < -SUM_W'(33554432)) rsp_tof_in = 26'sh2000000;
      else                                  rsp_tof_in = tof_sum[TOF_W-1:0];
      rsp_eok_in  = last.eok;
      rsp_wok_in  = last.wok;
      rsp_pa_in   = last.pa;
      rsp_pb_in   = last.pb;
      rsp_mask_in = last.mask;
      if (!last.eok) begin
         rsp_tof_in  = '0;
         rsp_pa_in   = '0;
         rsp_pb_in   = '0;
         rsp_mask_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= side_v_ff[ROOT_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_eok_ff  <= rsp_eok_in;
         rsp_wok_ff  <= rsp_wok_in;
         rsp_tof_ff  <= rsp_tof_in;
         rsp_pa_ff   <= rsp_pa_in;
         rsp_pb_ff   <= rsp_pb_in;
         rsp_mask_ff <= rsp_mask_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_ok   = rsp_eok_ff;
   assign rsp_walk_ok    = rsp_wok_ff;
   assign rsp_tof_ps     = rsp_tof_ff;
   assign rsp_pe_a       = rsp_pa_ff;
   assign rsp_pe_b       = rsp_pb_ff;
   assign rsp_class_mask = rsp_mask_ff;

endmodule
`default_nettype wire

[tb/tof_walk_correction_tb.sv]
`timescale 1ns / 1ps
module tof_walk_correction_tb;
   import tofwc_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT  = 3000;

   typedef struct {
      logic                    eok;
      logic                    wok;
      logic signed [TOF_W-1:0] tof;
      logic [PE_W-1:0]         pa;
      logic [PE_W-1:0]         pb;
      logic [MASK_W-1:0]       mask;
   } tof_result_type;

   typedef struct {
      logic [23:0] ta;
      logic [23:0] tb;
      logic [11:0] ha;
      logic [11:0] hb;
      bit          typed;
      tof_result_type res;
   } event_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [23:0] req_time_a = '0, req_time_b = '0;
   logic [11:0] req_height_a = '0, req_height_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_event_ok, rsp_walk_ok;
   logic signed [25:0] rsp_tof_ps;
   logic [16:0] rsp_pe_a, rsp_pe_b;
   logic [7:0] rsp_class_mask;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   cfg_type shadow_cfg;
   tof_result_type expected_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit no_gaps = 0;

   tof_walk_correction u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint walk_ps(longint a, longint b, longint c, longint q);
      longint unsigned mag, d, t;
      longint rt, p, lt;
      mag = (b < 0) ? -b : b;
      d = (4 * mag * mag) / q;
      t = (int_sqrt(d) + 1) >> 1;
      rt = (b < 0) ? -longint'(t) : longint'(t);
      p = c * q;
      mag = (p < 0) ? -p : p;
      t = (mag + (64'd1 << 17)) >> 18;
      lt = (p < 0) ? -longint'(t) : longint'(t);
      return a + rt + lt;
   endfunction

   function automatic tof_result_type corrected_tof(logic [23:0] ta, logic [23:0] tb,
                                                    logic [11:0] ha, logic [11:0] hb);
      tof_result_type r;
      longint pa, pb, qa, qb, tof, thr;
      r = '{default: '0};
      if (ta == 0 || tb == 0 || ha == 0 || hb == 0) return r;
      pa = (longint'(ha) * 5610 + 136970 + 128) >>> 8;
      pb = (longint'(hb) * 5741 + 147456 + 128) >>> 8;
      qa = pa - 896;
      qb = pb - 947;
      r.eok = 1'b1;
      r.wok = (qa > 0) && (qb > 0);
      tof = longint'(ta) - longint'(tb) - 550;
      if (r.wok)
         tof = tof - walk_ps(shadow_cfg.ofs1, shadow_cfg.root1, shadow_cfg.lin1, qa)
                   - walk_ps(shadow_cfg.ofs2, shadow_cfg.root2, shadow_cfg.lin2, qb);
      if (tof > 33554431) tof = 33554431;
      if (tof < -33554432) tof = -33554432;
      r.tof = TOF_W'(tof);
      r.pa = PE_W'(pa);
      r.pb = PE_W'(pb);
      for (int k = 0; k < 8; k++) begin
         thr = (k + 1) * longint'(shadow_cfg.step);
         if (pa > thr && pb > thr) r.mask[k] = 1'b1;
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_event(logic [23:0] ta, logic [23:0] tb, logic [11:0] ha,
                             logic [11:0] hb, bit typed, tof_result_type res);
      int g;
      @(negedge clock);
      req_valid <= 1'b1;
      req_time_a <= ta;
      req_time_b <= tb;
      req_height_a <= ha;
      req_height_b <= hb;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(typed ? res : corrected_tof(ta, tb, ha, hb));
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [23:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      unique case (idx)
         REG_OFS1:  shadow_cfg.ofs1  = data[OFS_W-1:0];
         REG_ROOT1: shadow_cfg.root1 = data;
         REG_LIN1:  shadow_cfg.lin1  = data;
         REG_OFS2:  shadow_cfg.ofs2  = data[OFS_W-1:0];
         REG_ROOT2: shadow_cfg.root2 = data;
         REG_LIN2:  shadow_cfg.lin2  = data;
         REG_STEP:  shadow_cfg.step  = data[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_cfg(logic [23:0] o1, logic [23:0] r1, logic [23:0] l1,
                           logic [23:0] o2, logic [23:0] r2, logic [23:0] l2,
                           logic [23:0] st);
      csr_write(REG_OFS1, o1);
      csr_write(REG_ROOT1, r1);
      csr_write(REG_LIN1, l1);
      csr_write(REG_OFS2, o2);
      csr_write(REG_ROOT2, r2);
      csr_write(REG_LIN2, l2);
      csr_write(REG_STEP, st);
   endtask

   function automatic logic [11:0] rand_height();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 12'd0;
      if (r < 30) return 12'($urandom_range(1, 40));
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [23:0] rand_time();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 24'd0;
      if (r < 40) return 24'(5000000 + $urandom_range(0, 20000));
      return 24'($urandom_range(0, 24'hFFFFFF));
   endfunction

   task automatic random_events(int n);
      tof_result_type none;
      none = '{default: '0};
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send_event(rand_time(), rand_time(), rand_height(), rand_height(), 0, none);
      end
      no_gaps = 0;
   endtask

   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 70) rsp_ready <= 1'b1;
      else if (r < 97) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 40) == 0);
   end

   always @(posedge clock) begin
      tof_result_type e;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: transaction with nothing expected", $time);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_event_ok !== e.eok) begin
               $display("%0t: event_ok exp %0d got %0d", $time, e.eok, rsp_event_ok);
               errors++;
            end
            if (rsp_walk_ok !== e.wok) begin
               $display("%0t: walk_ok exp %0d got %0d", $time, e.wok, rsp_walk_ok);
               errors++;
            end
            if (rsp_tof_ps !== e.tof) begin
               $display("%0t: tof_ps exp %0d got %0d", $time, e.tof, rsp_tof_ps);
               errors++;
            end
            if (rsp_pe_a !== e.pa) begin
               $display("%0t: pe_a exp %0d got %0d", $time, e.pa, rsp_pe_a);
               errors++;
            end
            if (rsp_pe_b !== e.pb) begin
               $display("%0t: pe_b exp %0d got %0d", $time, e.pb, rsp_pe_b);
               errors++;
            end
            if (rsp_class_mask !== e.mask) begin
               $display("%0t: class_mask exp %h got %h", $time, e.mask, rsp_class_mask);
               errors++;
            end
         end
      end
   end

   initial begin
      event_row_type rows[$];
      shadow_cfg = '{default: '0};
      shadow_cfg.step = STEP_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // rejected events, defaults, extremes
      rows.push_back('{24'd0, 24'd5, 12'd7, 12'd7, 1, '{0, 0, 0, 0, 0, 0}});
      rows.push_back('{24'd5, 24'd0, 12'd7, 12'd7, 1, '{0, 0, 0, 0, 0, 0}});
      rows.push_back('{24'd5, 24'd5, 12'd0, 12'd7, 1, '{0, 0, 0, 0, 0, 0}});
      rows.push_back('{24'd5, 24'd5, 12'd7, 12'd0, 1, '{0, 0, 0, 0, 0, 0}});
      rows.push_back('{24'd0, 24'd0, 12'd0, 12'd0, 1, '{0, 0, 0, 0, 0, 0}});
      rows.push_back('{24'd1, 24'd1, 12'd1, 12'd1, 1, '{1, 0, -550, 557, 598, 0}});
      rows.push_back('{24'hFFFFFF, 24'd1, 12'hFFF, 12'hFFF, 1,
                      '{1, 1, 16776664, 90273, 92410, 8'hFF}});
      rows.push_back('{24'd1, 24'hFFFFFF, 12'hFFF, 12'hFFF, 1,
                      '{1, 1, -16777764, 90273, 92410, 8'hFF}});
      rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 12'hFFF, 12'd1, 1,
                      '{1, 0, -550, 90273, 598, 0}});
      rows.push_back('{24'hAAAAAA, 24'h555555, 12'hAAA, 12'h555, 0, '{default: 0}});
      rows.push_back('{24'h555555, 24'hAAAAAA, 12'h555, 12'hAAA, 0, '{default: 0}});
      rows.push_back('{24'd1000, 24'd900, 12'd16, 12'd16, 0, '{default: 0}});
      rows.push_back('{24'd1000, 24'd900, 12'd17, 12'd18, 0, '{default: 0}});
      foreach (rows[i])
         send_event(rows[i].ta, rows[i].tb, rows[i].ha, rows[i].hb, rows[i].typed,
                    rows[i].res);
      drain();

      // coefficients at extremes, walk terms near the pedestal, saturation
      load_cfg(24'h100000, 24'h800000, 24'h800000, 24'h100000, 24'h800000, 24'h800000,
               24'd1);
      csr_write(REG_UNUSED, 24'hFFFFFF);
      for (int h = 14; h < 22; h++)
         send_event(24'hFFFFFF, 24'd1, 12'(h), 12'(h + 1), 0, '{default: 0});
      send_event(24'hFFFFFF, 24'd1, 12'hFFF, 12'hFFF, 0, '{default: 0});
      random_events(200);
      drain();

      load_cfg(24'h0FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h0FFFFF, 24'h7FFFFF, 24'h7FFFFF,
               24'd8191);
      send_event(24'd1, 24'hFFFFFF, 12'd17, 12'd18, 0, '{default: 0});
      random_events(200);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         load_cfg(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom_range(1, 8191)));
         if (ph == 2) csr_write(REG_STEP, 24'($urandom_range(1, 2000)));
         random_events(200);
         drain();
      end

      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
design/tofwc_pkg.sv
design/tofwc_front.sv
design/tofwc_root.sv
design/tof_walk_correction.sv
tb/tof_walk_correction_tb.sv
